FILE: design/hsa_pkg.sv
// hsa_pkg: shared constants, codes and types for the handle slot allocator.
// No dependencies; compiled first.
package hsa_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int ENT_W     = 32;
    localparam int OWNER_W   = 16;
    localparam int HINT_W    = 32;
    localparam int DIVCNT_W  = $clog2(HINT_W);
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [ENT_W-1:0] INVALID_ENT = '1;
    localparam logic [CNT_W-1:0] CAP_RESET   = CNT_W'(SLOTS);

    typedef enum logic [FUNC_W-1:0] {
        FN_ACQUIRE = 2'd0,
        FN_RELEASE = 2'd1,
        FN_CHECK   = 2'd2,
        FN_NEXT    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_OWNER    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_NONE     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_LIST_ID  = 1'b0,
        REG_CAPACITY = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_PRB_RD,
        S_PRB_CHK,
        S_CHK_RD,
        S_CHK_CMP,
        S_SCN_RD,
        S_SCN_CHK,
        S_DONE
    } state_t;

endpackage

FILE: design/hsa_if.sv
// hsa_req_if / hsa_rsp_if: valid/ready channels for request and result items.
// Depends on hsa_pkg for field widths.
interface hsa_req_if;
    logic                         valid;
    logic                         ready;
    logic [hsa_pkg::FUNC_W-1:0]   func;
    logic [hsa_pkg::OWNER_W-1:0]  owner_id;
    logic [hsa_pkg::SLOT_W-1:0]   slot;
    logic [hsa_pkg::ENT_W-1:0]    entity_id;

    modport source (output valid, func, owner_id, slot, entity_id, input ready);
    modport sink   (input valid, func, owner_id, slot, entity_id, output ready);
endinterface

interface hsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hsa_pkg::STATUS_W-1:0]  status;
    logic [hsa_pkg::OWNER_W-1:0]   out_owner_id;
    logic [hsa_pkg::SLOT_W-1:0]    out_slot;
    logic [hsa_pkg::ENT_W-1:0]     out_entity_id;
    logic [hsa_pkg::CNT_W-1:0]     active_count;
    logic [hsa_pkg::CNT_W-1:0]     slot_count;

    modport source (output valid, status, out_owner_id, out_slot, out_entity_id,
                    active_count, slot_count, input ready);
    modport sink   (input valid, status, out_owner_id, out_slot, out_entity_id,
                    active_count, slot_count, output ready);
endinterface

FILE: design/handle_slot_allocator.sv
// handle_slot_allocator: slot table, counters, search FSM and APB registers.
// Depends on hsa_pkg and the hsa_req_if / hsa_rsp_if interfaces.
//
// Slot-map handle allocator. Each table slot holds the entity id that owns it,
// or the all-ones id when free; the table is one synchronous RAM with a
// registered read. One item is worked at a time and gives one result item,
// held in an output register so the next item is taken while it waits.
// Work per item, from acceptance until the result is ready to load:
//   - errors found from the counters alone (full, invalid id, wrong owner,
//     out of range) and an acquire into an empty table: no RAM read;
//   - release / check valid: one RAM read and compare;
//   - acquire: one RAM read and check per probed slot, plus reducing the search
//     hint modulo the slot count (bit-serial remainder) when the hint is not
//     already below that count; the walk ends at the first free slot or
//     after slot_count probes, then appends;
//   - find next active: one read and check per slot from the start slot.
// Each probe or scan step is a RAM read followed by a check of the read data.
// Results then load from the pending-result registers into the output
// register once it is free.
// Registers (APB, 32-bit data, byte address 4*index):
//   0 list_id (16 bits), 1 instance_capacity (11 bits, reset 1024; values
//   above the table depth act as the depth). Writes are only legal while idle.
// The slot RAM has no reset: only slots below slot_count are ever read, and
// every one of those has been written.
module handle_slot_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsa_pkg::APB_AW-1:0]  paddr,
    input  logic [hsa_pkg::APB_DW-1:0]  pwdata,
    output logic [hsa_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    hsa_req_if.sink                     req,
    hsa_rsp_if.source                   rsp
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    hsa_pkg::state_t                     state_reg, state_next;

    logic [hsa_pkg::OWNER_W-1:0]         list_id_reg;
    logic [hsa_pkg::CNT_W-1:0]           cap_reg;

    logic [hsa_pkg::CNT_W-1:0]           used_reg, used_next;
    logic [hsa_pkg::CNT_W-1:0]           live_reg, live_next;
    logic [hsa_pkg::HINT_W-1:0]          hint_reg, hint_next;

    // latched request
    hsa_pkg::func_t                      op_func_reg, op_func_next;
    logic [hsa_pkg::OWNER_W-1:0]         op_owner_reg, op_owner_next;
    logic [hsa_pkg::SLOT_W-1:0]          op_slot_reg, op_slot_next;
    logic [hsa_pkg::ENT_W-1:0]           op_ent_reg, op_ent_next;

    // walk position (probe or scan) and probe count
    logic [hsa_pkg::CNT_W-1:0]           cur_reg, cur_next;
    logic [hsa_pkg::CNT_W-1:0]           prb_cnt_reg, prb_cnt_next;

    // bit-serial remainder of hint by slot count
    logic [hsa_pkg::CNT_W-1:0]           rem_reg, rem_next;
    logic [hsa_pkg::DIVCNT_W-1:0]        div_cnt_reg, div_cnt_next;

    // pending result
    hsa_pkg::status_t                    res_status_reg, res_status_next;
    logic [hsa_pkg::OWNER_W-1:0]         res_owner_reg, res_owner_next;
    logic [hsa_pkg::SLOT_W-1:0]          res_slot_reg, res_slot_next;
    logic [hsa_pkg::ENT_W-1:0]           res_ent_reg, res_ent_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    hsa_pkg::status_t                    out_status_reg, out_status_next;
    logic [hsa_pkg::OWNER_W-1:0]         out_owner_reg, out_owner_next;
    logic [hsa_pkg::SLOT_W-1:0]          out_slot_reg, out_slot_next;
    logic [hsa_pkg::ENT_W-1:0]           out_ent_reg, out_ent_next;
    logic [hsa_pkg::CNT_W-1:0]           out_live_reg, out_live_next;
    logic [hsa_pkg::CNT_W-1:0]           out_used_reg, out_used_next;

    // slot RAM
    logic [hsa_pkg::ENT_W-1:0]           slot_mem [hsa_pkg::SLOTS];
    logic [hsa_pkg::ENT_W-1:0]           rd_data_reg;
    logic                                mem_rd_en;
    logic [hsa_pkg::SLOT_W-1:0]          mem_rd_addr;
    logic                                mem_wr_en;
    logic [hsa_pkg::SLOT_W-1:0]          mem_wr_addr;
    logic [hsa_pkg::ENT_W-1:0]           mem_wr_data;

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    logic                                accept;
    logic                                out_free;
    logic [hsa_pkg::CNT_W-1:0]           eff_cap;
    logic                                acq_full;
    logic                                in_ent_bad;
    logic                                in_owner_bad;
    logic                                in_slot_oob;
    logic                                used_zero;
    logic                                hint_low;
    logic [hsa_pkg::CNT_W-1:0]           cur_inc;
    logic [hsa_pkg::CNT_W-1:0]           prb_inc;
    logic                                rd_free;
    logic [hsa_pkg::CNT_W:0]             div_shift;
    logic                                div_ge;
    logic [hsa_pkg::CNT_W-1:0]           div_rem;
    logic                                cfg_wr;
    hsa_pkg::reg_idx_t                   cfg_idx;

    assign accept       = req.valid && (state_reg == hsa_pkg::S_IDLE);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign eff_cap      = (cap_reg > hsa_pkg::CNT_W'(hsa_pkg::SLOTS))
                          ? hsa_pkg::CNT_W'(hsa_pkg::SLOTS) : cap_reg;
    assign acq_full     = live_reg >= eff_cap;
    assign in_ent_bad   = req.entity_id == hsa_pkg::INVALID_ENT;
    assign in_owner_bad = req.owner_id != list_id_reg;
    assign in_slot_oob  = {1'b0, req.slot} >= used_reg;
    assign used_zero    = used_reg == '0;
    assign hint_low     = hint_reg < hsa_pkg::HINT_W'(used_reg);
    assign cur_inc      = cur_reg + 1'b1;
    assign prb_inc      = prb_cnt_reg + 1'b1;
    assign rd_free      = rd_data_reg == hsa_pkg::INVALID_ENT;

    // one restoring step: shift in the next hint bit, subtract if it fits
    assign div_shift    = {rem_reg, hint_reg[div_cnt_reg]};
    assign div_ge       = div_shift >= {1'b0, used_reg};
    assign div_rem      = div_ge ? hsa_pkg::CNT_W'(div_shift - {1'b0, used_reg})
                                 : hsa_pkg::CNT_W'(div_shift);

    // ------------------------------------------------------------------
    // APB register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = hsa_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            hsa_pkg::REG_LIST_ID:  prdata = hsa_pkg::APB_DW'(list_id_reg);
            hsa_pkg::REG_CAPACITY: prdata = hsa_pkg::APB_DW'(cap_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_id_reg <= '0;
            cap_reg     <= hsa_pkg::CAP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                hsa_pkg::REG_LIST_ID:  list_id_reg <= pwdata[hsa_pkg::OWNER_W-1:0];
                hsa_pkg::REG_CAPACITY: cap_reg     <= pwdata[hsa_pkg::CNT_W-1:0];
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (hsa_pkg::func_t'(req.func) == hsa_pkg::FN_ACQUIRE)
                    begin
                        priority if (acq_full || in_ent_bad || used_zero)
                            state_next = hsa_pkg::S_DONE;
                        else if (hint_low)
                            state_next = hsa_pkg::S_PRB_RD;
                        else
                            state_next = hsa_pkg::S_DIV;
                    end
                    else if (in_owner_bad)
                        state_next = hsa_pkg::S_DONE;
                    else if (hsa_pkg::func_t'(req.func) == hsa_pkg::FN_NEXT)
                        state_next = in_slot_oob ? hsa_pkg::S_DONE : hsa_pkg::S_SCN_RD;
                    else
                        state_next = (in_ent_bad || in_slot_oob) ? hsa_pkg::S_DONE
                                                                 : hsa_pkg::S_CHK_RD;
                end
            end
            hsa_pkg::S_DIV:
                if (div_cnt_reg == '0)
                    state_next = hsa_pkg::S_PRB_RD;
            hsa_pkg::S_PRB_RD:
                state_next = hsa_pkg::S_PRB_CHK;
            hsa_pkg::S_PRB_CHK:
                state_next = (rd_free || prb_inc == used_reg) ? hsa_pkg::S_DONE
                                                              : hsa_pkg::S_PRB_RD;
            hsa_pkg::S_CHK_RD:
                state_next = hsa_pkg::S_CHK_CMP;
            hsa_pkg::S_CHK_CMP:
                state_next = hsa_pkg::S_DONE;
            hsa_pkg::S_SCN_RD:
                state_next = hsa_pkg::S_SCN_CHK;
            hsa_pkg::S_SCN_CHK:
                state_next = (!rd_free || cur_inc >= used_reg) ? hsa_pkg::S_DONE
                                                               : hsa_pkg::S_SCN_RD;
            hsa_pkg::S_DONE:
                if (out_free)
                    state_next = hsa_pkg::S_IDLE;
            default:
                state_next = hsa_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath
    // ------------------------------------------------------------------
    assign req.ready = state_reg == hsa_pkg::S_IDLE;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_owner_id  = out_owner_reg;
    assign rsp.out_slot      = out_slot_reg;
    assign rsp.out_entity_id = out_ent_reg;
    assign rsp.active_count  = out_live_reg;
    assign rsp.slot_count    = out_used_reg;

    always_comb
    begin
        used_next       = used_reg;
        live_next       = live_reg;
        hint_next       = hint_reg;
        op_func_next    = op_func_reg;
        op_owner_next   = op_owner_reg;
        op_slot_next    = op_slot_reg;
        op_ent_next     = op_ent_reg;
        cur_next        = cur_reg;
        prb_cnt_next    = prb_cnt_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        res_owner_next  = res_owner_reg;
        res_slot_next   = res_slot_reg;
        res_ent_next    = res_ent_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cur_reg[hsa_pkg::SLOT_W-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cur_reg[hsa_pkg::SLOT_W-1:0];
        mem_wr_data     = op_ent_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_owner_next  = out_owner_reg;
        out_slot_next   = out_slot_reg;
        out_ent_next    = out_ent_reg;
        out_live_next   = out_live_reg;
        out_used_next   = out_used_reg;

        unique case (state_reg)
            hsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_func_next    = hsa_pkg::func_t'(req.func);
                    op_owner_next   = req.owner_id;
                    op_slot_next    = req.slot;
                    op_ent_next     = req.entity_id;
                    res_status_next = hsa_pkg::ST_OK;
                    res_owner_next  = '0;
                    res_slot_next   = '0;
                    res_ent_next    = '0;
                    prb_cnt_next    = '0;
                    priority if (hsa_pkg::func_t'(req.func) == hsa_pkg::FN_ACQUIRE)
                    begin
                        priority if (acq_full)
                            res_status_next = hsa_pkg::ST_FULL;
                        else if (in_ent_bad)
                            res_status_next = hsa_pkg::ST_MISMATCH;
                        else if (used_zero)
                        begin
                            // empty table: append slot 0 right away
                            mem_wr_en      = 1'b1;
                            mem_wr_addr    = '0;
                            mem_wr_data    = req.entity_id;
                            used_next      = hsa_pkg::CNT_W'(1);
                            live_next      = live_reg + 1'b1;
                            res_owner_next = list_id_reg;
                            res_ent_next   = req.entity_id;
                        end
                        else if (hint_low)
                            cur_next = hint_reg[hsa_pkg::CNT_W-1:0];
                        else
                        begin
                            rem_next     = '0;
                            div_cnt_next = '1;
                        end
                    end
                    else if (in_owner_bad)
                        res_status_next = hsa_pkg::ST_OWNER;
                    else if (hsa_pkg::func_t'(req.func) == hsa_pkg::FN_NEXT)
                    begin
                        if (in_slot_oob)
                            res_status_next = hsa_pkg::ST_NONE;
                        else
                            cur_next = {1'b0, req.slot};
                    end
                    else if (in_ent_bad || in_slot_oob)
                        res_status_next = hsa_pkg::ST_MISMATCH;
                end
            end

            hsa_pkg::S_DIV:
            begin
                rem_next     = div_rem;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                    cur_next = div_rem;
            end

            hsa_pkg::S_PRB_RD:
                mem_rd_en = 1'b1;

            hsa_pkg::S_PRB_CHK:
            begin
                // the hint moves on every probe, the hit included
                hint_next    = hint_reg + 1'b1;
                prb_cnt_next = prb_inc;
                cur_next     = (cur_inc == used_reg) ? '0 : cur_inc;
                priority if (rd_free)
                begin
                    mem_wr_en      = 1'b1;
                    live_next      = live_reg + 1'b1;
                    res_owner_next = list_id_reg;
                    res_slot_next  = cur_reg[hsa_pkg::SLOT_W-1:0];
                    res_ent_next   = op_ent_reg;
                end
                else if (prb_inc == used_reg)
                begin
                    // every used slot taken: append, unless the table is full
                    if (used_reg >= hsa_pkg::CNT_W'(hsa_pkg::SLOTS))
                        res_status_next = hsa_pkg::ST_FULL;
                    else
                    begin
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = used_reg[hsa_pkg::SLOT_W-1:0];
                        used_next      = used_reg + 1'b1;
                        live_next      = live_reg + 1'b1;
                        res_owner_next = list_id_reg;
                        res_slot_next  = used_reg[hsa_pkg::SLOT_W-1:0];
                        res_ent_next   = op_ent_reg;
                    end
                end
            end

            hsa_pkg::S_CHK_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = op_slot_reg;
            end

            hsa_pkg::S_CHK_CMP:
            begin
                if (rd_data_reg != op_ent_reg)
                    res_status_next = hsa_pkg::ST_MISMATCH;
                else
                begin
                    res_owner_next = op_owner_reg;
                    res_slot_next  = op_slot_reg;
                    res_ent_next   = op_ent_reg;
                    if (op_func_reg == hsa_pkg::FN_RELEASE)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = op_slot_reg;
                        mem_wr_data = hsa_pkg::INVALID_ENT;
                        if (live_reg != '0)
                            live_next = live_reg - 1'b1;
                        if (hsa_pkg::HINT_W'(op_slot_reg) < hint_reg)
                            hint_next = hsa_pkg::HINT_W'(op_slot_reg);
                    end
                end
            end

            hsa_pkg::S_SCN_RD:
                mem_rd_en = 1'b1;

            hsa_pkg::S_SCN_CHK:
            begin
                cur_next = cur_inc;
                priority if (!rd_free)
                begin
                    res_owner_next = list_id_reg;
                    res_slot_next  = cur_reg[hsa_pkg::SLOT_W-1:0];
                    res_ent_next   = rd_data_reg;
                end
                else if (cur_inc >= used_reg)
                    res_status_next = hsa_pkg::ST_NONE;
            end

            hsa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_owner_next  = res_owner_reg;
                    out_slot_next   = res_slot_reg;
                    out_ent_next    = res_ent_reg;
                    out_live_next   = live_reg;
                    out_used_next   = used_reg;
                end
            end

            default:
                ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsa_pkg::S_IDLE;
            used_reg      <= '0;
            live_reg      <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_func_reg    <= op_func_next;
        op_owner_reg   <= op_owner_next;
        op_slot_reg    <= op_slot_next;
        op_ent_reg     <= op_ent_next;
        cur_reg        <= cur_next;
        prb_cnt_reg    <= prb_cnt_next;
        rem_reg        <= rem_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_owner_reg  <= res_owner_next;
        res_slot_reg   <= res_slot_next;
        res_ent_reg    <= res_ent_next;
        out_status_reg <= out_status_next;
        out_owner_reg  <= out_owner_next;
        out_slot_reg   <= out_slot_next;
        out_ent_reg    <= out_ent_next;
        out_live_reg   <= out_live_next;
        out_used_reg   <= out_used_next;
    end

    // ------------------------------------------------------------------
    // Slot RAM: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            slot_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= slot_mem[mem_rd_addr];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("active count above slot count");

    a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= hsa_pkg::CNT_W'(hsa_pkg::SLOTS))
        else $error("slot count above table depth");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hsa_pkg::S_PRB_CHK || state_reg == hsa_pkg::S_SCN_CHK)
        |-> cur_reg < used_reg)
        else $error("walk position outside used slots");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hsa_pkg::S_DIV |-> !used_zero)
        else $error("remainder by zero slot count");

    a_err_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != hsa_pkg::ST_OK)
        |-> (out_owner_reg == '0 && out_slot_reg == '0 && out_ent_reg == '0))
        else $error("error result carries a handle");

endmodule
